>>> hw/rtl/wfba_pkg.sv
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared codes and widths for the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

  localparam int SizeW   = 16;
  localparam int IndexW  = 5;
  localparam int TotalW  = 32;
  localparam int StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_GRANT  = 2'd0,
    ST_WAIT   = 2'd1,
    ST_LOADED = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

endpackage

>>> hw/rtl/wfba_in_if.sv
// ----------------------------------------------------------------------------
// wfba_in_if
// Input channel: load or allocation request with a size.
// ----------------------------------------------------------------------------
interface wfba_in_if;
  import wfba_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [SizeW-1:0] size;

  modport source (output valid, output op, output size, input ready);
  modport sink   (input valid, input op, input size, output ready);

endinterface

>>> hw/rtl/wfba_out_if.sv
// ----------------------------------------------------------------------------
// wfba_out_if
// Result channel: status, chosen block, sizes and the leftover total.
// ----------------------------------------------------------------------------
interface wfba_out_if;
  import wfba_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IndexW-1:0]  block_index;
  logic [SizeW-1:0]   size_before;
  logic [SizeW-1:0]   size_after;
  logic [TotalW-1:0]  leftover_total;

  modport source (output valid, output status, output block_index, output size_before,
                  output size_after, output leftover_total, input ready);
  modport sink   (input valid, input status, input block_index, input size_before,
                  input size_after, input leftover_total, output ready);

endinterface

>>> hw/rtl/wfba_cell.sv
// ----------------------------------------------------------------------------
// wfba_cell
// One table slot: holds a block's free size and folds it into the running
// maximum that travels down the chain, one cell per cycle.
// ----------------------------------------------------------------------------
module wfba_cell #(
  parameter int  NUM_BLOCKS = 32,
  parameter int  IDX        = 0,
  parameter type link_t     = logic,
  parameter type wr_t       = logic
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]   cnt_i,
  input  wr_t                               wr_i,
  input  link_t                             lnk_i,
  output link_t                             lnk_o
);
  import wfba_pkg::*;

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  logic [SizeW-1:0] free_q;
  logic             active;
  logic             take;
  link_t            lnk_d;
  link_t            lnk_q;

  assign active = (CW'(IDX) < cnt_i);
  // strict compare keeps the lowest block on ties
  assign take   = active && (!lnk_i.found || (free_q > lnk_i.size));

  always_comb begin
    lnk_d = lnk_i;
    if (take) begin
      lnk_d.found = 1'b1;
      lnk_d.size  = free_q;
      lnk_d.idx   = IW'(IDX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.wr && (wr_i.idx == IW'(IDX))) begin
      free_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lnk_q <= '0;
    end else begin
      lnk_q <= lnk_d;
    end
  end

  assign lnk_o = lnk_q;

endmodule

>>> hw/rtl/worst_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// worst_fit_block_allocator_core
// Worst-fit allocator over a chain of block cells.
// ----------------------------------------------------------------------------
// A load goes from acceptance straight to the final state, which writes the
// block into the table unless it is full and registers the result. An
// allocation request sends a search token that walks the chain of NUM_BLOCKS
// cells one cell per cycle, starting at the accepting edge; the scan state
// then latches the winner, and the final state updates the table and
// registers the result. The final state waits while an earlier result has not
// been taken. One item is in flight at a time; a new item is accepted as soon
// as the previous one has been written to the output register, even while
// that result still waits to be taken.
module worst_fit_block_allocator_core #(
  parameter int NUM_BLOCKS = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  wfba_in_if.sink    in_i,
  wfba_out_if.source out_o
);
  import wfba_pkg::*;

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  typedef struct packed {
    logic             tok;
    logic             found;
    logic [SizeW-1:0] size;
    logic [IW-1:0]    idx;
  } link_t;

  typedef struct packed {
    logic             wr;
    logic [IW-1:0]    idx;
    logic [SizeW-1:0] data;
  } wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e              state_q;
  logic                op_q;
  logic [SizeW-1:0]    size_q;
  logic [CW-1:0]       count_q;
  logic [TotalW-1:0]   sum_q;
  logic                best_found_q;
  logic [SizeW-1:0]    best_size_q;
  logic [IW-1:0]       best_idx_q;

  logic                out_valid_q;
  status_e             status_q;
  logic [IndexW-1:0]   index_q;
  logic [SizeW-1:0]    before_q;
  logic [SizeW-1:0]    after_q;
  logic [TotalW-1:0]   total_q;

  link_t               chain [NUM_BLOCKS+1];
  wr_t                 wr_cmd;

  logic                in_fire;
  logic                out_free;
  logic                fin_go;
  logic                fit;
  logic                full;
  logic [SizeW-1:0]    after;
  logic [TotalW:0]     sum_add;
  logic [TotalW-1:0]   sum_sat;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign fin_go     = (state_q == S_FIN) && out_free;

  assign fit     = best_found_q && (best_size_q >= size_q);
  assign after   = best_size_q - size_q;
  assign sum_add = {1'b0, sum_q} + {{(TotalW + 1 - SizeW){1'b0}}, after};
  assign sum_sat = sum_add[TotalW] ? {TotalW{1'b1}} : sum_add[TotalW-1:0];
  assign full    = (count_q == CW'(NUM_BLOCKS));

  // search token enters the chain with the request
  assign chain[0] = '{tok: in_fire && (in_i.op == OP_REQUEST), found: 1'b0,
                      size: '0, idx: '0};

  always_comb begin
    wr_cmd.wr   = 1'b0;
    wr_cmd.idx  = count_q[IW-1:0];
    wr_cmd.data = size_q;
    if (op_q == OP_REQUEST) begin
      wr_cmd.idx  = best_idx_q;
      wr_cmd.data = after;
      wr_cmd.wr   = fin_go && fit;
    end else begin
      wr_cmd.wr   = fin_go && !full;
    end
  end

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    wfba_cell #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .IDX        (g),
      .link_t     (link_t),
      .wr_t       (wr_t)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cnt_i  (count_q),
      .wr_i   (wr_cmd),
      .lnk_i  (chain[g]),
      .lnk_o  (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
      op_q         <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q   <= in_i.op;
            size_q <= in_i.size;
            state_q <= (in_i.op == OP_REQUEST) ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          if (chain[NUM_BLOCKS].tok) begin
            best_found_q <= chain[NUM_BLOCKS].found;
            best_size_q  <= chain[NUM_BLOCKS].size;
            best_idx_q   <= chain[NUM_BLOCKS].idx;
            state_q      <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
            if (op_q == OP_REQUEST) begin
              if (fit) begin
                status_q <= ST_GRANT;
                index_q  <= IndexW'(best_idx_q);
                before_q <= best_size_q;
                after_q  <= after;
                total_q  <= sum_sat;
                sum_q    <= sum_sat;
              end else begin
                status_q <= ST_WAIT;
                index_q  <= '0;
                before_q <= '0;
                after_q  <= '0;
                total_q  <= sum_q;
              end
            end else if (full) begin
              status_q <= ST_FULL;
              index_q  <= '0;
              before_q <= '0;
              after_q  <= '0;
              total_q  <= sum_q;
            end else begin
              status_q <= ST_LOADED;
              index_q  <= IndexW'(count_q);
              before_q <= '0;
              after_q  <= size_q;
              total_q  <= sum_q;
              count_q  <= count_q + CW'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.block_index    = index_q;
  assign out_o.size_before    = before_q;
  assign out_o.size_after     = after_q;
  assign out_o.leftover_total = total_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NUM_BLOCKS))
    else $error("block count beyond table depth");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[NUM_BLOCKS].tok |-> (state_q == S_SCAN))
    else $error("search token left the chain outside a scan");

  a_grant_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_GRANT)) |-> (after_q <= before_q))
    else $error("grant grew the block");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cmd.wr |-> (state_q == S_FIN) && !chain[0].tok)
    else $error("table write outside the update cycle");

endmodule

>>> dv/worst_fit_block_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// worst_fit_block_allocator_core_tb
// Drives loads and allocation requests into the worst-fit allocator, predicts
// every result from a local copy of the block table and checks each result
// field by field, under several idle and stall patterns and output pressure.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator_core_tb;
  import wfba_pkg::*;

  localparam int NUM_BLOCKS     = 32;
  localparam int RESET_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 145;

  typedef struct packed {
    status_e           status;
    logic [IndexW-1:0] block_index;
    logic [SizeW-1:0]  size_before;
    logic [SizeW-1:0]  size_after;
    logic [TotalW-1:0] leftover_total;
  } alloc_result_t;

  logic clk_i;
  logic rst_ni;

  wfba_in_if  in_if ();
  wfba_out_if out_if ();

  worst_fit_block_allocator_core #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // local copy of the allocator state
  logic [SizeW-1:0]  free_size [NUM_BLOCKS];
  int                blocks_loaded = 0;
  logic [TotalW-1:0] leftover_acc  = '0;

  alloc_result_t alloc_due [$];
  int            errors         = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  bit            hold_req       = 1'b0;
  int            hold_left      = 0;
  int            stall_cycles   = 0;

  always #6 clk_i = ~clk_i;

  // lowest-numbered block with the largest remainder, -1 when the table is empty
  function automatic int widest_block();
    int pick;
    pick = -1;
    for (int b = 0; b < blocks_loaded; b++)
      if (pick < 0 || free_size[b] > free_size[pick]) pick = b;
    return pick;
  endfunction

  function automatic alloc_result_t predict_alloc(op_e op, logic [SizeW-1:0] size);
    alloc_result_t    res;
    int               pick;
    logic [SizeW-1:0] remain;
    logic [TotalW:0]  sum;
    res.status      = ST_WAIT;
    res.block_index = '0;
    res.size_before = '0;
    res.size_after  = '0;
    if (op == OP_LOAD) begin
      if (blocks_loaded < NUM_BLOCKS) begin
        free_size[blocks_loaded] = size;
        res.status      = ST_LOADED;
        res.block_index = IndexW'(blocks_loaded);
        res.size_after  = size;
        blocks_loaded++;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      pick = widest_block();
      if (pick >= 0 && free_size[pick] >= size) begin
        remain          = free_size[pick] - size;
        res.status      = ST_GRANT;
        res.block_index = IndexW'(pick);
        res.size_before = free_size[pick];
        res.size_after  = remain;
        free_size[pick] = remain;
        sum             = {1'b0, leftover_acc} + remain;
        leftover_acc    = sum[TotalW] ? '1 : sum[TotalW-1:0];
      end
    end
    res.leftover_total = leftover_acc;
    return res;
  endfunction

  task automatic send_item(input op_e op, input logic [SizeW-1:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.size  <= size;
    do @(posedge clk_i); while (!in_if.ready);
    alloc_due.push_back(predict_alloc(op, size));
  endtask

  task automatic pause_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (alloc_due.size() != 0);
  endtask

  // counted is low for loads into a full table, which the block answers with a full status
  task automatic send_random_item(output bit counted);
    op_e              op;
    logic [SizeW-1:0] size;
    int               pick;
    int               cap;
    int               roll;
    pick = widest_block();
    cap  = (pick < 0) ? 0 : int'(free_size[pick]);
    op   = ($urandom_range(99) < ((blocks_loaded < NUM_BLOCKS) ? 35 : 8)) ?
           OP_LOAD : OP_REQUEST;
    roll = $urandom_range(99);
    if (op == OP_LOAD) begin
      size = (roll < 15) ? SizeW'($urandom_range(15)) : SizeW'($urandom);
    end else if (roll < 60) begin
      size = SizeW'($urandom_range((cap < 64) ? cap : 64));
    end else if (roll < 64) begin
      size = SizeW'(cap);
    end else if (roll < 74) begin
      // one past the largest remainder does not fit, unless that remainder is already 16'hFFFF
      size = (cap >= 65535) ? '1 : SizeW'(cap + 1);
    end else if (roll < 79) begin
      size = '0;
    end else if (roll < 89) begin
      size = SizeW'($urandom_range(cap));
    end else begin
      size = SizeW'($urandom);
    end
    counted = !(op == OP_LOAD && blocks_loaded >= NUM_BLOCKS);
    send_item(op, size);
  endtask

  task automatic test_empty_table();
    send_item(OP_REQUEST, 16'h0000);
    send_item(OP_REQUEST, 16'hFFFF);
  endtask

  task automatic test_load_and_grant();
    send_item(OP_LOAD, 16'h0000);
    send_item(OP_REQUEST, 16'h0000);
    send_item(OP_REQUEST, 16'h0001);
    send_item(OP_LOAD, 16'hFFFF);
    send_item(OP_LOAD, 16'hFFFF);
    // equal remainders go to the lower block number
    send_item(OP_REQUEST, 16'hFFFF);
    send_item(OP_REQUEST, 16'hFFFF);
    send_item(OP_REQUEST, 16'h0001);
    send_item(OP_LOAD, 16'd1000);
    send_item(OP_LOAD, 16'd1000);
    send_item(OP_REQUEST, 16'h0000);
    send_item(OP_REQUEST, 16'd999);
    send_item(OP_REQUEST, 16'd1000);
    send_item(OP_REQUEST, 16'h0002);
    send_item(OP_REQUEST, 16'h0001);
    send_item(OP_LOAD, 16'hAAAA);
    send_item(OP_REQUEST, 16'h5555);
  endtask

  task automatic test_random_mix(input int idle_pct, input int stall_pct);
    int done;
    bit counted;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < PHASE_ITEMS) begin
      send_random_item(counted);
      if (counted) done++;
    end
  endtask

  // output held off while the input keeps offering loads and requests
  task automatic test_output_backpressure();
    bit counted;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (12) send_random_item(counted);
  endtask

  task automatic test_table_full();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (blocks_loaded < NUM_BLOCKS) send_item(OP_LOAD, SizeW'($urandom));
    send_item(OP_LOAD, 16'hFFFF);
    send_item(OP_LOAD, 16'h0000);
    send_item(OP_REQUEST, 16'h0000);
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (alloc_due.size() == 0) begin
        $display("%0t: result with nothing due, expected none, actual status %0d index %0d",
                 $time, out_if.status, out_if.block_index);
        errors++;
      end else begin
        want = alloc_due.pop_front();
        compare_field("status", 32'(want.status), 32'(out_if.status));
        compare_field("block_index", 32'(want.block_index), 32'(out_if.block_index));
        compare_field("size_before", 32'(want.size_before), 32'(out_if.size_before));
        compare_field("size_after", 32'(want.size_after), 32'(out_if.size_after));
        compare_field("leftover_total", want.leftover_total, out_if.leftover_total);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_if.valid = 1'b0;
    in_if.op    = OP_LOAD;
    in_if.size  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_load_and_grant();
    pause_until_drained();
    test_random_mix(0, 0);
    pause_until_drained();
    test_output_backpressure();
    pause_until_drained();
    test_random_mix(74, 0);
    pause_until_drained();
    test_random_mix(0, 74);
    pause_until_drained();
    test_random_mix(20, 20);
    pause_until_drained();
    test_table_full();
    pause_until_drained();

    // a late or extra result would still show up here
    repeat (NUM_BLOCKS + 8) @(posedge clk_i);
    if (errors == 0 && alloc_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
